### rtl/core/assert_macros.svh
// Assertion macros shared by the sorted set table modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check cons in the same cycle as ante
`define SST_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted set table assertion failed");

// check cons in the cycle after ante
`define SST_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted set table assertion failed");

`endif

### rtl/core/sst_pkg.sv
// Types and constants of the sorted set table
package sst_pkg;

	localparam int KEY_W  = 32;
	localparam int MODE_W = 2;
	localparam int POS_W  = 9;

	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PROBE,
		OP_EVAL,
		OP_LOCATE,
		OP_SHIFT_UP,
		OP_SHIFT_DOWN,
		OP_SHIFT_STEP,
		OP_INSERT,
		OP_DELETE,
		OP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   status;
	} dp_cmd_t;

	typedef struct packed {
		logic search_done;
		logic hit;
		logic found;
		logic full;
		logic shift_done;
	} dp_stat_t;

endpackage

### rtl/core/sst_req_if.sv
// Request channel of the sorted set table
interface sst_req_if import sst_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic signed [KEY_W-1:0] key;

	modport source (output valid, output mode, output key, input ready);
	modport sink (input valid, input mode, input key, output ready);
endinterface

### rtl/core/sst_rsp_if.sv
// Response channel of the sorted set table
interface sst_rsp_if import sst_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             was_present;
	logic [POS_W-1:0] position;
	logic [POS_W-1:0] entry_count;
	logic             status;

	modport source (output valid, output was_present, output position, output entry_count,
		output status, input ready);
	modport sink (input valid, input was_present, input position, input entry_count,
		input status, output ready);
endinterface

### rtl/core/sst_dp.sv
// Datapath of the sorted set table: key store, search bounds, shifter and result register
`include "assert_macros.svh"

module sst_dp import sst_pkg::*; #(
	parameter int CAPACITY = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	input  logic signed [KEY_W-1:0] req_key,
	output dp_stat_t                stat,
	output logic                    was_present,
	output logic [POS_W-1:0]        position,
	output logic [POS_W-1:0]        entry_count,
	output logic                    status
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [KEY_W-1:0] mem [CAPACITY];
	logic signed [KEY_W-1:0] key_q;
	logic signed [KEY_W-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [CW-1:0] mid_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] wa_q;
	logic          found_q;
	logic          up_q;
	logic          pend_q;

	logic [CW-1:0] mid;
	logic [CW-1:0] idx_dn;
	logic [CW-1:0] idx_up;
	logic          more;
	logic          hit;
	logic          less;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic signed [KEY_W-1:0] wr_data;

	assign mid    = lo_q + ((hi_q - lo_q) >> 1);
	assign idx_dn = idx_q - CW'(1);
	assign idx_up = idx_q + CW'(1);
	assign more   = up_q ? (idx_q > pos_q) : (idx_up < count_q);
	assign hit    = (rd_q == key_q);
	assign less   = (rd_q < key_q);

	assign stat.search_done = !(lo_q < hi_q);
	assign stat.hit         = hit;
	assign stat.found       = found_q;
	assign stat.full        = (count_q == CW'(CAPACITY));
	assign stat.shift_done  = !more && !pend_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = mid[AW-1:0];
		if (cmd.op == OP_PROBE) begin
			rd_en = 1'b1;
		end else if (cmd.op == OP_SHIFT_STEP && more) begin
			rd_en   = 1'b1;
			rd_addr = up_q ? idx_dn[AW-1:0] : idx_up[AW-1:0];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wa_q[AW-1:0];
		wr_data = rd_q;
		if (cmd.op == OP_SHIFT_STEP && pend_q) begin
			wr_en = 1'b1;
		end else if (cmd.op == OP_INSERT) begin
			wr_en   = 1'b1;
			wr_addr = pos_q[AW-1:0];
			wr_data = key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			found_q <= 1'b0;
			up_q    <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					found_q <= 1'b0;
				end
				OP_EVAL: begin
					if (hit) begin
						found_q <= 1'b1;
					end
				end
				OP_SHIFT_UP: begin
					up_q   <= 1'b1;
					pend_q <= 1'b0;
				end
				OP_SHIFT_DOWN: begin
					up_q   <= 1'b0;
					pend_q <= 1'b0;
				end
				OP_SHIFT_STEP: begin
					pend_q <= more;
				end
				OP_INSERT: begin
					count_q <= count_q + CW'(1);
				end
				OP_DELETE: begin
					count_q <= count_q - CW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				key_q <= req_key;
				lo_q  <= '0;
				hi_q  <= count_q;
			end
			OP_PROBE: begin
				mid_q <= mid;
			end
			OP_EVAL: begin
				if (hit) begin
					pos_q <= mid_q;
				end else if (less) begin
					lo_q <= mid_q + CW'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			OP_LOCATE: begin
				pos_q <= lo_q;
			end
			OP_SHIFT_UP: begin
				idx_q <= count_q;
			end
			OP_SHIFT_DOWN: begin
				idx_q <= pos_q;
			end
			OP_SHIFT_STEP: begin
				if (more) begin
					wa_q  <= idx_q;
					idx_q <= up_q ? idx_dn : idx_up;
				end
			end
			OP_RESULT: begin
				was_present <= found_q;
				position    <= POS_W'(pos_q);
				entry_count <= POS_W'(count_q);
				status      <= cmd.status;
			end
			default: ;
		endcase
	end

	`SST_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(CAPACITY))
	`SST_ASSERT_NEXT(a_insert_grows, cmd.op == OP_INSERT, count_q == $past(count_q) + CW'(1))
	`SST_ASSERT_NOW(a_full_drop, cmd.op == OP_RESULT && cmd.status == STATUS_FULL,
		!found_q && stat.full)

endmodule

### rtl/core/sst_ctrl.sv
// Controller of the sorted set table: search, shift and reply sequencing
`include "assert_macros.svh"

module sst_ctrl import sst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [MODE_W-1:0] req_mode,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  dp_stat_t          stat,
	output dp_cmd_t           cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROBE,
		S_EVAL,
		S_DECIDE,
		S_SHIFT,
		S_FINISH,
		S_REPLY
	} state_t;

	state_t            state_q;
	logic [MODE_W-1:0] mode_q;
	logic              status_q;
	logic              rsp_valid_q;

	logic reply_go;
	logic add_go;
	logic add_drop;
	logic rem_go;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign reply_go  = (state_q == S_REPLY) && (!rsp_valid_q || rsp_ready);
	assign add_go    = (mode_q == MODE_ADD) && !stat.found && !stat.full;
	assign add_drop  = (mode_q == MODE_ADD) && !stat.found && stat.full;
	assign rem_go    = (mode_q == MODE_REMOVE) && stat.found;

	always_comb begin
		cmd.op     = OP_NONE;
		cmd.status = status_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op = OP_LOAD;
				end
			end
			S_PROBE: begin
				cmd.op = stat.search_done ? OP_LOCATE : OP_PROBE;
			end
			S_EVAL: begin
				cmd.op = OP_EVAL;
			end
			S_DECIDE: begin
				if (add_go) begin
					cmd.op = OP_SHIFT_UP;
				end else if (rem_go) begin
					cmd.op = OP_SHIFT_DOWN;
				end
			end
			S_SHIFT: begin
				cmd.op = OP_SHIFT_STEP;
			end
			S_FINISH: begin
				cmd.op = (mode_q == MODE_ADD) ? OP_INSERT : OP_DELETE;
			end
			S_REPLY: begin
				if (reply_go) begin
					cmd.op = OP_RESULT;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_QUERY;
			status_q    <= STATUS_DONE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (reply_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						mode_q   <= req_mode;
						status_q <= STATUS_DONE;
						state_q  <= S_PROBE;
					end
				end
				S_PROBE: begin
					state_q <= stat.search_done ? S_DECIDE : S_EVAL;
				end
				S_EVAL: begin
					state_q <= stat.hit ? S_DECIDE : S_PROBE;
				end
				S_DECIDE: begin
					case (mode_q)
						MODE_ADD: begin
							if (add_drop) begin
								status_q <= STATUS_FULL;
							end
							state_q <= add_go ? S_SHIFT : S_REPLY;
						end
						MODE_REMOVE: begin
							state_q <= rem_go ? S_SHIFT : S_REPLY;
						end
						MODE_QUERY: begin
							state_q <= S_REPLY;
						end
						default: begin
							state_q <= S_REPLY;
						end
					endcase
				end
				S_SHIFT: begin
					if (stat.shift_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					state_q <= S_REPLY;
				end
				S_REPLY: begin
					if (reply_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SST_ASSERT_NOW(a_rsp_from_reply, $rose(rsp_valid_q), $past(state_q) == S_REPLY)
	`SST_ASSERT_NOW(a_shift_mode, state_q == S_SHIFT,
		mode_q == MODE_ADD || mode_q == MODE_REMOVE)

endmodule

### rtl/core/sorted_set_table.sv
// Top level of the sorted set table
//
//  channel  dir  beat payload                              handshake
//  req      in   mode, key                                 valid / ready
//  rsp      out  was_present, position, entry_count, status valid / ready
//
// One request at a time. Each probe of the search reads the key store and then evaluates it, up to
// ceil(log2(count + 1)) probes, bounded by the single read port of the key store.
// An add or remove then moves its entries at one per cycle in the shift state, and the decide
// and reply states of control go with every request.
// Reset clears the entry count and control state, not the key store; it needs no clearing pass.
// A finished beat waits in the output register while the next request is taken.
module sorted_set_table import sst_pkg::*; #(
	parameter int CAPACITY = 256
) (
	input logic       clk,
	input logic       arst_n,
	sst_req_if.sink   req,
	sst_rsp_if.source rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_mode  (req.mode),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sst_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req_key     (req.key),
		.stat        (stat),
		.was_present (rsp.was_present),
		.position    (rsp.position),
		.entry_count (rsp.entry_count),
		.status      (rsp.status)
	);

endmodule

### tb/sorted_set_table_tb.sv
// Testbench of the sorted set table: directed and random requests against a self-built predictor
`timescale 1ns / 1ps

module sorted_set_table_tb import sst_pkg::*; ();

	localparam int CAP        = 256;
	localparam int POOL_N     = 320;
	localparam int LONG_HOLD  = 400;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_WAIT = 320;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFFFFFF;
	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh80000000;

	typedef struct packed {
		logic             was_present;
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] entry_count;
		logic             status;
	} lookup_result_t;

	logic clk;
	logic arst_n;

	sst_req_if req_if ();
	sst_rsp_if rsp_if ();

	sorted_set_table #(
		.CAPACITY(CAP)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	logic signed [KEY_W-1:0] held_keys [CAP];
	int                      held_n;
	lookup_result_t          pending_results [$];
	logic signed [KEY_W-1:0] key_pool [POOL_N];
	int                      fail_cnt;
	int                      quiet_cycles;
	bit                      idle_on;
	bit                      hold_long;

	always #5 clk = ~clk;

	// update the set the way the block should and return the lookup it reports
	function automatic lookup_result_t apply_request(logic [MODE_W-1:0] m,
			logic signed [KEY_W-1:0] k);
		lookup_result_t r;
		int lo;
		int hi;
		int mid;
		int i;
		bit hit;
		lo  = 0;
		hi  = held_n;
		hit = 0;
		while (lo < hi && !hit) begin
			mid = lo + (hi - lo) / 2;
			if (held_keys[mid] == k) begin
				hit = 1;
				lo  = mid;
			end else if (held_keys[mid] < k) begin
				lo = mid + 1;
			end else begin
				hi = mid;
			end
		end
		r.was_present = hit;
		r.position    = lo[POS_W-1:0];
		r.status      = STATUS_DONE;
		if (m == MODE_ADD && !hit) begin
			if (held_n >= CAP) begin
				r.status = STATUS_FULL;
			end else begin
				for (i = held_n; i > lo; i--)
					held_keys[i] = held_keys[i-1];
				held_keys[lo] = k;
				held_n++;
			end
		end else if (m == MODE_REMOVE && hit) begin
			for (i = lo; i + 1 < held_n; i++)
				held_keys[i] = held_keys[i+1];
			held_n--;
		end
		r.entry_count = held_n[POS_W-1:0];
		return r;
	endfunction

	task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			fail_cnt++;
		end
	endtask

	always @(posedge clk) begin : score
		lookup_result_t want;
		if (arst_n) begin
			quiet_cycles++;
			if (req_if.valid && req_if.ready) begin
				pending_results.push_back(apply_request(req_if.mode, req_if.key));
				quiet_cycles = 0;
			end
			if (rsp_if.valid && rsp_if.ready) begin
				quiet_cycles = 0;
				if (pending_results.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual pos %0d count %0d",
						$time, rsp_if.position, rsp_if.entry_count);
					fail_cnt++;
				end else begin
					want = pending_results.pop_front();
					check_field("was_present", 32'(want.was_present), 32'(rsp_if.was_present));
					check_field("position", 32'(want.position), 32'(rsp_if.position));
					check_field("entry_count", 32'(want.entry_count), 32'(rsp_if.entry_count));
					check_field("status", 32'(want.status), 32'(rsp_if.status));
				end
			end
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				rsp_if.ready <= 1'b0;
			end else if (hold_long) begin
				rsp_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_long = 0;
				rsp_if.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				rsp_if.ready <= 1'b1;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	task automatic send_beat(logic [MODE_W-1:0] m, logic signed [KEY_W-1:0] k);
		req_if.valid <= 1'b1;
		req_if.mode  <= m;
		req_if.key   <= k;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	function automatic logic [MODE_W-1:0] pick_mode(int add_w, int rem_w);
		int r;
		r = $urandom_range(0, 99);
		if (r < add_w)
			return MODE_ADD;
		if (r < add_w + rem_w)
			return MODE_REMOVE;
		if (r < 97)
			return MODE_QUERY;
		return MODE_UNUSED;
	endfunction

	function automatic logic signed [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return $urandom;
		if (r < 6 && held_n > 0)
			return held_keys[$urandom_range(0, held_n - 1)];
		return key_pool[$urandom_range(0, POOL_N - 1)];
	endfunction

	task automatic test_directed();
		send_beat(MODE_QUERY, KEY_MIN);
		send_beat(MODE_REMOVE, 32'sd0);
		send_beat(MODE_ADD, 32'sd0);
		send_beat(MODE_ADD, KEY_MAX);
		send_beat(MODE_ADD, KEY_MIN);
		send_beat(MODE_ADD, -32'sd1);
		send_beat(MODE_ADD, 32'sd1);
		send_beat(MODE_ADD, 32'sd0);
		send_beat(MODE_QUERY, KEY_MAX);
		send_beat(MODE_QUERY, KEY_MIN);
		send_beat(MODE_UNUSED, KEY_MAX);
		send_beat(MODE_UNUSED, 32'sd5);
		send_beat(MODE_REMOVE, -32'sd1);
		send_beat(MODE_REMOVE, 32'sd12345);
		send_beat(MODE_ADD, 32'sh55555555);
		send_beat(MODE_ADD, 32'shAAAAAAAA);
		send_beat(MODE_QUERY, 32'shAAAAAAAA);
		send_beat(MODE_REMOVE, KEY_MIN);
		send_beat(MODE_REMOVE, KEY_MAX);
		send_beat(MODE_REMOVE, 32'sd0);
		send_beat(MODE_REMOVE, 32'sd1);
		send_beat(MODE_REMOVE, 32'sh55555555);
		send_beat(MODE_REMOVE, 32'shAAAAAAAA);
		send_beat(MODE_REMOVE, KEY_MIN);
		send_beat(MODE_QUERY, 32'sd0);
	endtask

	task automatic test_full_store();
		int n;
		n = 0;
		while (held_n < CAP && n < 2 * CAP) begin
			send_beat(MODE_ADD, (n % 64 == 0) ? KEY_MAX : $urandom);
			n++;
		end
		repeat (20) send_beat(MODE_ADD, $urandom);
		repeat (10) send_beat(MODE_ADD, held_keys[$urandom_range(0, CAP - 1)]);
		send_beat(MODE_ADD, KEY_MIN);
		repeat (10) send_beat(MODE_QUERY, pick_key());
		n = 0;
		while (held_n > 0 && n < 2 * CAP) begin
			send_beat(MODE_REMOVE, held_keys[$urandom_range(0, held_n - 1)]);
			n++;
		end
	endtask

	task automatic test_backpressure();
		hold_long = 1;
		repeat (12) send_beat(pick_mode(60, 30), pick_key());
	endtask

	task automatic test_random_mix(int n, int add_w, int rem_w);
		repeat (n) send_beat(pick_mode(add_w, rem_w), pick_key());
	endtask

	task automatic test_no_idle();
		idle_on = 0;
		test_random_mix(150, 45, 40);
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.mode  = MODE_ADD;
		req_if.key   = '0;
		held_n       = 0;
		fail_cnt     = 0;
		quiet_cycles = 0;
		idle_on      = 1;
		hold_long    = 0;
		foreach (key_pool[i])
			key_pool[i] = $urandom;
		key_pool[0] = KEY_MIN;
		key_pool[1] = KEY_MAX;
		key_pool[2] = '0;
		key_pool[3] = -32'sd1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_store();
		test_backpressure();
		test_random_mix(400, 70, 20);
		test_random_mix(400, 45, 45);
		test_random_mix(400, 20, 70);
		test_no_idle();

		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_cnt == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/sst_pkg.sv
rtl/core/sst_req_if.sv
rtl/core/sst_rsp_if.sv
rtl/core/sst_dp.sv
rtl/core/sst_ctrl.sv
rtl/core/sorted_set_table.sv
tb/sorted_set_table_tb.sv
